### src/adcseq_pkg.sv
// Shared types, codes and constants of the ADC scan sequencer.
package adcseq_pkg;

  // Limit on scanned channels, applied on top of channel_count
  localparam int MAX_CHANNELS = 16;

  // Data-ready timeout: check count that fires a reinit, and saturation value
  localparam logic [8:0] WAIT_LIMIT = 9'h0FF;
  localparam logic [8:0] WAIT_MAX   = 9'h1FF;

  // Configuration register indexes
  localparam logic [1:0] CFG_LEGACY_FLOW   = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] CFG_SETTLE_TICKS  = 2'd2;

  // Configuration reset values
  localparam logic       LEGACY_FLOW_RST   = 1'b0;
  localparam logic [4:0] CHANNEL_COUNT_RST = 5'd1;
  localparam logic [7:0] SETTLE_TICKS_RST  = 8'd8;

  // Input operations
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_IR_START = 2'd1;
  localparam logic [1:0] OP_IR_END   = 2'd2;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_OPEN    = 4'd1;
  localparam logic [3:0] PH_SETTLE  = 4'd2;
  localparam logic [3:0] PH_TRIG_I  = 4'd3;
  localparam logic [3:0] PH_READ_I  = 4'd4;
  localparam logic [3:0] PH_TRIG_V  = 4'd5;
  localparam logic [3:0] PH_READ_V  = 4'd6;
  localparam logic [3:0] PH_CLOSE   = 4'd7;
  localparam logic [3:0] PH_PARK    = 4'd8;
  localparam logic [3:0] PH_TRIG_IV = 4'd9;

  // Result actions
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_OPEN      = 4'd1;
  localparam logic [3:0] ACT_RESET_MUX = 4'd2;
  localparam logic [3:0] ACT_CONVERT   = 4'd3;
  localparam logic [3:0] ACT_TRIG_I    = 4'd4;
  localparam logic [3:0] ACT_TRIG_V    = 4'd5;
  localparam logic [3:0] ACT_READ_I    = 4'd6;
  localparam logic [3:0] ACT_READ_V    = 4'd7;
  localparam logic [3:0] ACT_TRIG_IV   = 4'd8;
  localparam logic [3:0] ACT_REINIT    = 4'd9;

  typedef struct packed {
    logic       legacy_flow;
    logic [4:0] channel_count;
    logic [7:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  ir_channel;
    logic        drdy_low;
    logic [23:0] adc_data;
  } item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [3:0]  mux_address;
    logic        store_current;
    logic        store_voltage;
    logic [3:0]  sample_channel;
    logic [23:0] stored_code;
    logic        new_sample;
    logic        ir_hold_ready;
  } res_t;

  typedef struct packed {
    logic [3:0] phase;
    logic [7:0] settle_count;
    logic [3:0] current_channel;
    logic       ir_active;
    logic       ir_switched;
    logic [3:0] ir_target;
    logic [3:0] saved_channel;
    logic [8:0] ready_wait_count;
    logic       ir_parked;
  } seq_state_t;

endpackage

### src/adcseq_ifs.sv
// Valid/ready channel interfaces of the ADC scan sequencer.
interface adcseq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  ir_channel;
  logic        drdy_low;
  logic [23:0] adc_data;

  modport source (output valid, operation, ir_channel, drdy_low, adc_data, input ready);
  modport sink   (input valid, operation, ir_channel, drdy_low, adc_data, output ready);
endinterface

interface adcseq_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  action;
  logic [3:0]  mux_address;
  logic        store_current;
  logic        store_voltage;
  logic [3:0]  sample_channel;
  logic [23:0] stored_code;
  logic        new_sample;
  logic        ir_hold_ready;

  modport source (output valid, action, mux_address, store_current, store_voltage,
                  sample_channel, stored_code, new_sample, ir_hold_ready, input ready);
  modport sink   (input valid, action, mux_address, store_current, store_voltage,
                  sample_channel, stored_code, new_sample, ir_hold_ready, output ready);
endinterface

interface adcseq_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/adcseq_step.sv
// Next-state and result logic for one sequencer step.
module adcseq_step (
  input  adcseq_pkg::cfg_t       cfg,
  input  adcseq_pkg::seq_state_t st,
  input  adcseq_pkg::item_t      item,
  output adcseq_pkg::seq_state_t st_nxt,
  output adcseq_pkg::res_t       res
);

  logic [4:0] chan_inc;
  logic [3:0] chan_next;
  logic [7:0] settle_inc;
  logic       settle_done;
  logic [8:0] wait_inc;
  logic       wait_expired;

  // Round-robin channel advance
  always_comb begin
    chan_inc = {1'b0, st.current_channel} + 5'd1;
    if ((chan_inc >= cfg.channel_count) || (32'(chan_inc) >= adcseq_pkg::MAX_CHANNELS)) begin
      chan_next = 4'd0;
    end else begin
      chan_next = chan_inc[3:0];
    end
  end

  // Settle counter and data-ready timeout
  assign settle_inc   = st.settle_count + 8'd1;
  assign settle_done  = settle_inc >= cfg.settle_ticks;
  assign wait_inc     = (st.ready_wait_count < adcseq_pkg::WAIT_MAX) ?
                        st.ready_wait_count + 9'd1 : st.ready_wait_count;
  assign wait_expired = st.ready_wait_count >= adcseq_pkg::WAIT_LIMIT;

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (item.operation)
      adcseq_pkg::OP_IR_START: begin
        st_nxt.saved_channel = st.current_channel;
        st_nxt.ir_target     = item.ir_channel;
        st_nxt.ir_active     = 1'b1;
        st_nxt.ir_parked     = 1'b0;
      end
      adcseq_pkg::OP_IR_END: begin
        st_nxt.current_channel = st.saved_channel;
        st_nxt.ir_active       = 1'b0;
        st_nxt.phase           = adcseq_pkg::PH_IDLE;
        st_nxt.ir_switched     = 1'b0;
      end
      adcseq_pkg::OP_TICK: begin
        if (cfg.legacy_flow) begin
          // Old board: separate convert and triggers, unconditional reads
          case (st.phase)
            adcseq_pkg::PH_IDLE: begin
              st_nxt.phase           = adcseq_pkg::PH_OPEN;
              st_nxt.settle_count    = 8'd0;
              st_nxt.current_channel = 4'd0;
            end
            adcseq_pkg::PH_OPEN: begin
              st_nxt.settle_count = 8'd0;
              if (st.ir_active) begin
                st_nxt.current_channel = st.ir_target;
                res.action             = adcseq_pkg::ACT_RESET_MUX;
                res.mux_address        = st.ir_target;
                st_nxt.phase           = adcseq_pkg::PH_PARK;
              end else begin
                res.action      = adcseq_pkg::ACT_OPEN;
                res.mux_address = st.current_channel;
                st_nxt.phase    = adcseq_pkg::PH_SETTLE;
              end
            end
            adcseq_pkg::PH_SETTLE: begin
              st_nxt.settle_count = settle_inc;
              if (settle_done) begin
                st_nxt.phase        = adcseq_pkg::PH_TRIG_I;
                res.action          = adcseq_pkg::ACT_CONVERT;
                st_nxt.settle_count = 8'd0;
              end
            end
            adcseq_pkg::PH_TRIG_I: begin
              res.action   = adcseq_pkg::ACT_TRIG_I;
              st_nxt.phase = adcseq_pkg::PH_READ_I;
            end
            adcseq_pkg::PH_READ_I: begin
              res.action         = adcseq_pkg::ACT_READ_I;
              res.store_current  = 1'b1;
              res.sample_channel = st.current_channel;
              res.stored_code    = item.adc_data;
              st_nxt.phase       = adcseq_pkg::PH_TRIG_V;
            end
            adcseq_pkg::PH_TRIG_V: begin
              res.action   = adcseq_pkg::ACT_TRIG_V;
              st_nxt.phase = adcseq_pkg::PH_READ_V;
            end
            adcseq_pkg::PH_READ_V: begin
              res.action         = adcseq_pkg::ACT_READ_V;
              res.store_voltage  = 1'b1;
              res.sample_channel = st.current_channel;
              res.stored_code    = item.adc_data;
              res.new_sample     = 1'b1;
              st_nxt.phase       = adcseq_pkg::PH_CLOSE;
            end
            adcseq_pkg::PH_CLOSE: begin
              if (!st.ir_active) begin
                st_nxt.current_channel = chan_next;
              end
              st_nxt.phase = adcseq_pkg::PH_OPEN;
            end
            adcseq_pkg::PH_PARK: begin
            end
            default: begin
              st_nxt.phase = adcseq_pkg::PH_IDLE;
            end
          endcase
        end else begin
          // Newer board: joint trigger, polled data-ready
          case (st.phase)
            adcseq_pkg::PH_IDLE: begin
              st_nxt.phase           = adcseq_pkg::PH_OPEN;
              st_nxt.settle_count    = 8'd0;
              st_nxt.current_channel = 4'd0;
            end
            adcseq_pkg::PH_OPEN: begin
              st_nxt.settle_count = 8'd0;
              st_nxt.phase        = adcseq_pkg::PH_SETTLE;
              res.action          = adcseq_pkg::ACT_OPEN;
              if (st.ir_active) begin
                st_nxt.ir_switched     = 1'b1;
                st_nxt.current_channel = st.ir_target;
                res.mux_address        = st.ir_target;
              end else begin
                res.mux_address = st.current_channel;
              end
            end
            adcseq_pkg::PH_SETTLE: begin
              st_nxt.settle_count = settle_inc;
              if (settle_done) begin
                st_nxt.phase = (st.ir_active && st.ir_switched) ?
                               adcseq_pkg::PH_PARK : adcseq_pkg::PH_TRIG_IV;
                st_nxt.settle_count = 8'd0;
              end
            end
            adcseq_pkg::PH_TRIG_IV: begin
              res.action              = adcseq_pkg::ACT_TRIG_IV;
              st_nxt.phase            = adcseq_pkg::PH_READ_I;
              st_nxt.ready_wait_count = 9'd0;
            end
            adcseq_pkg::PH_READ_I, adcseq_pkg::PH_READ_V: begin
              if (!item.drdy_low) begin
                if (st.phase == adcseq_pkg::PH_READ_I) begin
                  res.action   = adcseq_pkg::ACT_READ_I;
                  st_nxt.phase = adcseq_pkg::PH_READ_V;
                end else begin
                  res.action   = adcseq_pkg::ACT_READ_V;
                  st_nxt.phase = adcseq_pkg::PH_CLOSE;
                end
                // zero codes are dropped
                if (item.adc_data != 24'd0) begin
                  res.store_current  = (st.phase == adcseq_pkg::PH_READ_I);
                  res.store_voltage  = (st.phase == adcseq_pkg::PH_READ_V);
                  res.new_sample     = (st.phase == adcseq_pkg::PH_READ_V);
                  res.sample_channel = st.current_channel;
                  res.stored_code    = item.adc_data;
                end
              end else begin
                st_nxt.ready_wait_count = wait_inc;
                if (wait_expired) begin
                  res.action             = adcseq_pkg::ACT_REINIT;
                  st_nxt.current_channel = 4'd0;
                  st_nxt.phase           = adcseq_pkg::PH_IDLE;
                  st_nxt.ir_active       = 1'b0;
                  st_nxt.ir_switched     = 1'b0;
                  st_nxt.saved_channel   = 4'd0;
                end
              end
            end
            adcseq_pkg::PH_CLOSE: begin
              if (!st.ir_active) begin
                st_nxt.current_channel = chan_next;
                st_nxt.phase           = adcseq_pkg::PH_OPEN;
              end else if (st.ir_parked) begin
                st_nxt.phase = adcseq_pkg::PH_PARK;
              end else begin
                st_nxt.current_channel = st.ir_target;
                st_nxt.phase           = adcseq_pkg::PH_OPEN;
              end
            end
            adcseq_pkg::PH_PARK: begin
              st_nxt.ir_parked = 1'b1;
            end
            default: begin
              st_nxt.phase = adcseq_pkg::PH_IDLE;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
    res.ir_hold_ready = st_nxt.ir_parked;
  end

endmodule

### src/adc_scan_sequencer_with_ir_hold_core.sv
// Top level of the ADC scan sequencer with IR hold.
//
// Channels: in_ch carries one command per transfer (tick, IR start, IR end)
// with the converter data-ready pin and read data sampled for that tick.
// out_ch returns exactly one result per command: the converter/mux action,
// an optional current or voltage store, the new-sample mark and the IR hold
// ready flag.
// cfg_ch writes legacy_flow, channel_count and settle_ticks by index; it is
// always ready and must be used only while no command is in flight.
// An accepted command is registered in the input register, and its result
// is registered once the result register is free or draining.
// Throughput: one command per cycle while out_ch is not stalled; the
// combinational step logic between the two registers allows that rate.
// Reset (rst_n low at a clock edge) empties both registers, puts the
// sequencer in idle on channel 0 and loads the register defaults.
// When the receiver stalls the result holds in the result register, one
// further command waits in the input register, and in_ch.ready then drops.
module adc_scan_sequencer_with_ir_hold_core (
  input  logic                clk,
  input  logic                rst_n,
  adcseq_in_if.sink           in_ch,
  adcseq_out_if.source        out_ch,
  adcseq_cfg_if.sink          cfg_ch
);

  adcseq_pkg::cfg_t       cfg_r;
  adcseq_pkg::seq_state_t st_r;
  adcseq_pkg::seq_state_t st_nxt;
  adcseq_pkg::item_t      item_r;
  adcseq_pkg::res_t       res_r;
  adcseq_pkg::res_t       res_nxt;
  logic                   item_valid_r;
  logic                   res_valid_r;
  logic                   advance;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.legacy_flow   <= adcseq_pkg::LEGACY_FLOW_RST;
      cfg_r.channel_count <= adcseq_pkg::CHANNEL_COUNT_RST;
      cfg_r.settle_ticks  <= adcseq_pkg::SETTLE_TICKS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        adcseq_pkg::CFG_LEGACY_FLOW:   cfg_r.legacy_flow   <= cfg_ch.data[0];
        adcseq_pkg::CFG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_ch.data[4:0];
        adcseq_pkg::CFG_SETTLE_TICKS:  cfg_r.settle_ticks  <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the step fires when the result register is free or draining
  assign advance     = item_valid_r && (!res_valid_r || out_ch.ready);
  assign in_ch.ready = !item_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.operation  <= in_ch.operation;
      item_r.ir_channel <= in_ch.ir_channel;
      item_r.drdy_low   <= in_ch.drdy_low;
      item_r.adc_data   <= in_ch.adc_data;
    end
  end

  // Step logic
  adcseq_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase            <= adcseq_pkg::PH_IDLE;
      st_r.settle_count     <= 8'd0;
      st_r.current_channel  <= 4'd0;
      st_r.ir_active        <= 1'b0;
      st_r.ir_switched      <= 1'b0;
      st_r.ir_target        <= 4'd0;
      st_r.saved_channel    <= 4'd0;
      st_r.ready_wait_count <= 9'd0;
      st_r.ir_parked        <= 1'b0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = res_valid_r;
  assign out_ch.action         = res_r.action;
  assign out_ch.mux_address    = res_r.mux_address;
  assign out_ch.store_current  = res_r.store_current;
  assign out_ch.store_voltage  = res_r.store_voltage;
  assign out_ch.sample_channel = res_r.sample_channel;
  assign out_ch.stored_code    = res_r.stored_code;
  assign out_ch.new_sample     = res_r.new_sample;
  assign out_ch.ir_hold_ready  = res_r.ir_hold_ready;

endmodule

### src/adcseq_checker.sv
// Port-level checks of the sequencer result channel, bound to the top level.
module adcseq_checker (
  input logic          clk,
  input logic          rst_n,
  adcseq_out_if.source out_ch
);

  // A stalled result holds its action and sample
  ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.action) && $stable(out_ch.stored_code))
    else $error("result changed while stalled");

  // At most one converter code is stored per result
  ap_one_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.store_current && out_ch.store_voltage))
    else $error("current and voltage stored together");

  // A completed pair always comes with the voltage store
  ap_pair_on_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.new_sample |->
      out_ch.store_voltage && (out_ch.action == adcseq_pkg::ACT_READ_V))
    else $error("new sample without voltage store");

  // Mux address only accompanies a mux open or a mux reset
  ap_mux_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.action != adcseq_pkg::ACT_OPEN) &&
      (out_ch.action != adcseq_pkg::ACT_RESET_MUX) |-> out_ch.mux_address == 4'd0)
    else $error("mux address outside a mux open");

  // Sample fields are clear without a store
  ap_sample_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.store_current && !out_ch.store_voltage |->
      (out_ch.stored_code == 24'd0) && (out_ch.sample_channel == 4'd0))
    else $error("sample fields set without a store");

endmodule

bind adc_scan_sequencer_with_ir_hold_core adcseq_checker u_adcseq_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);

### tb/testbench.sv
// Self-checking testbench for the ADC scan sequencer with IR hold.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code that the sequencer ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;

  adcseq_in_if  in_ch();
  adcseq_out_if out_ch();
  adcseq_cfg_if cfg_ch();

  adc_scan_sequencer_with_ir_hold_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Commands waiting for the driver, and results the sequencer owes us
  adcseq_pkg::item_t pending_cmds[$];
  adcseq_pkg::res_t  predicted_results[$];
  int    cmds_queued;
  int    results_seen;
  int    mismatch_count;
  int    hold_requests;

  // Predictor copy of the sequencer state and its registers
  adcseq_pkg::seq_state_t seq_st;
  adcseq_pkg::cfg_t       cfg_st;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [3:0] next_scan_channel(input logic [3:0] ch);
    int n;
    n = ch + 1;
    if (n >= cfg_st.channel_count || n >= adcseq_pkg::MAX_CHANNELS) n = 0;
    return n[3:0];
  endfunction

  // Counts one not-ready check; returns 1 when the converter reinit fires
  function automatic bit ready_timed_out();
    logic [8:0] old_count;
    old_count = seq_st.ready_wait_count;
    if (seq_st.ready_wait_count < adcseq_pkg::WAIT_MAX) seq_st.ready_wait_count++;
    if (old_count >= adcseq_pkg::WAIT_LIMIT) begin
      seq_st.current_channel = '0;
      seq_st.phase = adcseq_pkg::PH_IDLE;
      seq_st.ir_active = 1'b0;
      seq_st.ir_switched = 1'b0;
      seq_st.saved_channel = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic adcseq_pkg::res_t step_sequencer(input adcseq_pkg::item_t cmd);
    adcseq_pkg::res_t r;
    r = '0;
    case (cmd.operation)
      adcseq_pkg::OP_IR_START: begin
        seq_st.saved_channel = seq_st.current_channel;
        seq_st.ir_target = cmd.ir_channel;
        seq_st.ir_active = 1'b1;
        seq_st.ir_parked = 1'b0;
      end
      adcseq_pkg::OP_IR_END: begin
        seq_st.current_channel = seq_st.saved_channel;
        seq_st.ir_active = 1'b0;
        seq_st.phase = adcseq_pkg::PH_IDLE;
        seq_st.ir_switched = 1'b0;
      end
      adcseq_pkg::OP_TICK: begin
        if (cfg_st.legacy_flow) begin
          // old board: separate convert and triggers, unconditional reads
          case (seq_st.phase)
            adcseq_pkg::PH_IDLE: begin
              seq_st.phase = adcseq_pkg::PH_OPEN;
              seq_st.settle_count = '0;
              seq_st.current_channel = '0;
            end
            adcseq_pkg::PH_OPEN: begin
              seq_st.settle_count = '0;
              if (seq_st.ir_active) begin
                seq_st.current_channel = seq_st.ir_target;
                r.action = adcseq_pkg::ACT_RESET_MUX;
                seq_st.phase = adcseq_pkg::PH_PARK;
              end else begin
                r.action = adcseq_pkg::ACT_OPEN;
                seq_st.phase = adcseq_pkg::PH_SETTLE;
              end
              r.mux_address = seq_st.current_channel;
            end
            adcseq_pkg::PH_SETTLE: begin
              seq_st.settle_count = seq_st.settle_count + 8'd1;
              if (seq_st.settle_count >= cfg_st.settle_ticks) begin
                seq_st.phase = adcseq_pkg::PH_TRIG_I;
                r.action = adcseq_pkg::ACT_CONVERT;
                seq_st.settle_count = '0;
              end
            end
            adcseq_pkg::PH_TRIG_I: begin
              r.action = adcseq_pkg::ACT_TRIG_I;
              seq_st.phase = adcseq_pkg::PH_READ_I;
            end
            adcseq_pkg::PH_READ_I: begin
              r.action = adcseq_pkg::ACT_READ_I;
              r.store_current = 1'b1;
              r.sample_channel = seq_st.current_channel;
              r.stored_code = cmd.adc_data;
              seq_st.phase = adcseq_pkg::PH_TRIG_V;
            end
            adcseq_pkg::PH_TRIG_V: begin
              r.action = adcseq_pkg::ACT_TRIG_V;
              seq_st.phase = adcseq_pkg::PH_READ_V;
            end
            adcseq_pkg::PH_READ_V: begin
              r.action = adcseq_pkg::ACT_READ_V;
              r.store_voltage = 1'b1;
              r.sample_channel = seq_st.current_channel;
              r.stored_code = cmd.adc_data;
              r.new_sample = 1'b1;
              seq_st.phase = adcseq_pkg::PH_CLOSE;
            end
            adcseq_pkg::PH_CLOSE: begin
              if (!seq_st.ir_active)
                seq_st.current_channel = next_scan_channel(seq_st.current_channel);
              seq_st.phase = adcseq_pkg::PH_OPEN;
            end
            adcseq_pkg::PH_PARK: ;
            default: seq_st.phase = adcseq_pkg::PH_IDLE;
          endcase
        end else begin
          // newer board: joint trigger, data-ready polling, nonzero stores
          case (seq_st.phase)
            adcseq_pkg::PH_IDLE: begin
              seq_st.phase = adcseq_pkg::PH_OPEN;
              seq_st.settle_count = '0;
              seq_st.current_channel = '0;
            end
            adcseq_pkg::PH_OPEN: begin
              seq_st.settle_count = '0;
              seq_st.phase = adcseq_pkg::PH_SETTLE;
              if (seq_st.ir_active) begin
                seq_st.ir_switched = 1'b1;
                seq_st.current_channel = seq_st.ir_target;
              end
              r.action = adcseq_pkg::ACT_OPEN;
              r.mux_address = seq_st.current_channel;
            end
            adcseq_pkg::PH_SETTLE: begin
              seq_st.settle_count = seq_st.settle_count + 8'd1;
              if (seq_st.settle_count >= cfg_st.settle_ticks) begin
                seq_st.phase = (seq_st.ir_active && seq_st.ir_switched) ?
                               adcseq_pkg::PH_PARK : adcseq_pkg::PH_TRIG_IV;
                seq_st.settle_count = '0;
              end
            end
            adcseq_pkg::PH_TRIG_IV: begin
              r.action = adcseq_pkg::ACT_TRIG_IV;
              seq_st.phase = adcseq_pkg::PH_READ_I;
              seq_st.ready_wait_count = '0;
            end
            adcseq_pkg::PH_READ_I: begin
              if (!cmd.drdy_low) begin
                r.action = adcseq_pkg::ACT_READ_I;
                if (cmd.adc_data != '0) begin
                  r.store_current = 1'b1;
                  r.sample_channel = seq_st.current_channel;
                  r.stored_code = cmd.adc_data;
                end
                seq_st.phase = adcseq_pkg::PH_READ_V;
              end else if (ready_timed_out()) begin
                r.action = adcseq_pkg::ACT_REINIT;
              end
            end
            adcseq_pkg::PH_READ_V: begin
              if (!cmd.drdy_low) begin
                r.action = adcseq_pkg::ACT_READ_V;
                if (cmd.adc_data != '0) begin
                  r.store_voltage = 1'b1;
                  r.sample_channel = seq_st.current_channel;
                  r.stored_code = cmd.adc_data;
                  r.new_sample = 1'b1;
                end
                seq_st.phase = adcseq_pkg::PH_CLOSE;
              end else if (ready_timed_out()) begin
                r.action = adcseq_pkg::ACT_REINIT;
              end
            end
            adcseq_pkg::PH_CLOSE: begin
              if (!seq_st.ir_active) begin
                seq_st.current_channel = next_scan_channel(seq_st.current_channel);
                seq_st.phase = adcseq_pkg::PH_OPEN;
              end else if (seq_st.ir_parked) begin
                seq_st.phase = adcseq_pkg::PH_PARK;
              end else begin
                seq_st.current_channel = seq_st.ir_target;
                seq_st.phase = adcseq_pkg::PH_OPEN;
              end
            end
            adcseq_pkg::PH_PARK: seq_st.ir_parked = 1'b1;
            default: seq_st.phase = adcseq_pkg::PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase
    r.ir_hold_ready = seq_st.ir_parked;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking helpers
  // ---------------------------------------------------------------------------
  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic string fmt_result(input adcseq_pkg::res_t r);
    return $sformatf("act=%0d mux=%0d si=%0b sv=%0b ch=%0d code=%06h new=%0b hold=%0b",
                     r.action, r.mux_address, r.store_current, r.store_voltage,
                     r.sample_channel, r.stored_code, r.new_sample, r.ir_hold_ready);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input logic [1:0] op, input logic [3:0] ch,
                           input logic drdy, input logic [23:0] data);
    adcseq_pkg::item_t c;
    c.operation = op;
    c.ir_channel = ch;
    c.drdy_low = drdy;
    c.adc_data = data;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  // Random commands; an outage holds data-ready off long enough for a reinit
  task automatic queue_scan_cmds(input int n, input bit with_outage);
    int outage_at;
    int outage_left;
    int roll;
    logic [1:0] op;
    logic drdy;
    logic [23:0] data;
    outage_at = with_outage ? int'($urandom_range(0, n / 2)) : -1;
    outage_left = 0;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: data = '0;
        1: data = 24'hFF_FFFF;
        default: data = 24'($urandom);
      endcase
      if (i == outage_at) outage_left = $urandom_range(265, 300);
      if (outage_left > 0) begin
        op = adcseq_pkg::OP_TICK;
        drdy = 1'b1;
        outage_left--;
      end else begin
        roll = $urandom_range(0, 199);
        if (roll < 4) op = adcseq_pkg::OP_IR_START;
        else if (roll < 10) op = adcseq_pkg::OP_IR_END;
        else if (roll < 12) op = OP_UNUSED;
        else op = adcseq_pkg::OP_TICK;
        drdy = ($urandom_range(0, 9) == 0);
      end
      queue_cmd(op, 4'($urandom_range(0, 15)), drdy, data);
    end
  endtask

  // Sender pause: nothing new until every queued command has its result
  task automatic wait_all_results();
    @(posedge clk);
    while (results_seen != cmds_queued) @(posedge clk);
  endtask

  // Register write; bits above the field carry random noise
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value, input int width);
    logic [7:0] noise;
    noise = 8'($urandom);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value | (noise & (8'hFF << width));
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setup(input logic legacy, input logic [4:0] count,
                             input logic [7:0] settle);
    wait_all_results();
    write_reg(adcseq_pkg::CFG_LEGACY_FLOW, {7'd0, legacy}, 1);
    write_reg(adcseq_pkg::CFG_CHANNEL_COUNT, {3'd0, count}, 5);
    write_reg(adcseq_pkg::CFG_SETTLE_TICKS, settle, 8);
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: bursts with random gaps
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin : drive_cmds
    adcseq_pkg::item_t c;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        c = pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.operation <= c.operation;
        in_ch.ir_channel <= c.ir_channel;
        in_ch.drdy_low <= c.drdy_low;
        in_ch.adc_data <= c.adc_data;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: stall modes, plus a long hold on request
  // ---------------------------------------------------------------------------
  int hold_left;
  int holds_served;
  int stall_mode;
  int mode_left;
  int stall_phase;

  always @(posedge clk) begin : accept_results
    logic rdy;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
      holds_served = 0;
      mode_left = 0;
      stall_phase = 0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        stall_phase++;
        case (stall_mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = 1'($urandom_range(0, 1));
          default: rdy = (stall_phase % 4 == 0);
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction on command and register transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : predict
    adcseq_pkg::item_t c;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c.operation = in_ch.operation;
      c.ir_channel = in_ch.ir_channel;
      c.drdy_low = in_ch.drdy_low;
      c.adc_data = in_ch.adc_data;
      predicted_results.push_back(step_sequencer(c));
    end
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        adcseq_pkg::CFG_LEGACY_FLOW:   cfg_st.legacy_flow = cfg_ch.data[0];
        adcseq_pkg::CFG_CHANNEL_COUNT: cfg_st.channel_count = cfg_ch.data[4:0];
        adcseq_pkg::CFG_SETTLE_TICKS:  cfg_st.settle_ticks = cfg_ch.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result check, field by field against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    adcseq_pkg::res_t got;
    adcseq_pkg::res_t want;
    string diffs;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.action = out_ch.action;
      got.mux_address = out_ch.mux_address;
      got.store_current = out_ch.store_current;
      got.store_voltage = out_ch.store_voltage;
      got.sample_channel = out_ch.sample_channel;
      got.stored_code = out_ch.stored_code;
      got.new_sample = out_ch.new_sample;
      got.ir_hold_ready = out_ch.ir_hold_ready;
      results_seen++;
      if (predicted_results.size() == 0) begin
        note_failure($sformatf("unexpected result: %s", fmt_result(got)));
      end else begin
        want = predicted_results.pop_front();
        diffs = "";
        if (got.action !== want.action) diffs = {diffs, " action"};
        if (got.mux_address !== want.mux_address) diffs = {diffs, " mux_address"};
        if (got.store_current !== want.store_current) diffs = {diffs, " store_current"};
        if (got.store_voltage !== want.store_voltage) diffs = {diffs, " store_voltage"};
        if (got.sample_channel !== want.sample_channel) diffs = {diffs, " sample_channel"};
        if (got.stored_code !== want.stored_code) diffs = {diffs, " stored_code"};
        if (got.new_sample !== want.new_sample) diffs = {diffs, " new_sample"};
        if (got.ir_hold_ready !== want.ir_hold_ready) diffs = {diffs, " ir_hold_ready"};
        if (diffs != "")
          note_failure($sformatf("result %0d differs in%s\n  exp: %s\n  act: %s",
                                 results_seen, diffs, fmt_result(want), fmt_result(got)));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run limit
  // ---------------------------------------------------------------------------
  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = adcseq_pkg::OP_TICK;
    in_ch.ir_channel = '0;
    in_ch.drdy_low = 1'b0;
    in_ch.adc_data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = adcseq_pkg::CFG_LEGACY_FLOW;
    cfg_ch.data = '0;
    cmds_queued = 0;
    results_seen = 0;
    mismatch_count = 0;
    hold_requests = 0;
    seq_st = '0;
    seq_st.phase = adcseq_pkg::PH_IDLE;
    cfg_st.legacy_flow = adcseq_pkg::LEGACY_FLOW_RST;
    cfg_st.channel_count = adcseq_pkg::CHANNEL_COUNT_RST;
    cfg_st.settle_ticks = adcseq_pkg::SETTLE_TICKS_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed walk through the newer flow: two channels, one settle tick
    apply_setup(1'b0, 5'd2, 8'd1);
    queue_cmd(OP_UNUSED, 4'hF, 1'b1, 24'hFF_FFFF);
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0001);   // idle -> open
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // open mux 0
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // settle done
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // trigger both
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b1, 24'h12_3456);   // data not ready
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'hFF_FFFF);   // read I, full scale
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // read V, zero read
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // close -> channel 1
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // read I, zero read
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h5A_A5C3);   // read V
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // close, wraps to 0
    queue_cmd(adcseq_pkg::OP_IR_START, 4'hF, 1'b1, 24'h00_0000);
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // open IR target
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // settle -> park
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // parked
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);
    queue_cmd(adcseq_pkg::OP_IR_END, 4'h0, 1'b0, 24'h00_0000);
    queue_cmd(adcseq_pkg::OP_TICK, 4'h0, 1'b0, 24'h00_0000);   // restart at channel 0
    queue_cmd(adcseq_pkg::OP_IR_START, 4'h0, 1'b0, 24'hFF_FFFF);
    queue_cmd(adcseq_pkg::OP_IR_END, 4'hF, 1'b1, 24'h00_0000);

    // Newer flow, all channels; long receiver hold, then a sender pause
    apply_setup(1'b0, 5'd16, 8'd1);
    queue_scan_cmds(250, 1'b1);
    hold_requests++;
    wait_all_results();
    queue_scan_cmds(250, 1'b0);

    apply_setup(1'b1, 5'd4, 8'd2);
    queue_scan_cmds(400, 1'b0);

    apply_setup(1'b0, 5'd5, 8'd3);
    queue_scan_cmds(400, 1'b1);

    apply_setup(1'b1, 5'd1, 8'd1);
    queue_scan_cmds(200, 1'b0);

    apply_setup(1'b0, 5'd3, 8'd255);
    queue_scan_cmds(300, 1'b0);

    // Zero channel count keeps the scan on channel 0
    apply_setup(1'b0, 5'd0, 8'd1);
    queue_scan_cmds(150, 1'b0);

    // Drain with a bound, then let anything stray arrive before the final check
    for (int k = 0; k < 5000 && results_seen != cmds_queued; k++) @(posedge clk);
    repeat (5) @(posedge clk);
    if (results_seen != cmds_queued || predicted_results.size() != 0)
      note_failure($sformatf("%0d commands queued, %0d results seen, %0d predictions left",
                             cmds_queued, results_seen, predicted_results.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
